>>> hdl/segint_pkg.sv
// Shared types and constants for the segment intersection pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none
package segint_pkg;

  // Width of one output coordinate.
  localparam int OUT_W = 32;

  // Per-item control that travels with the data between modules.
  typedef struct packed {
    logic vld;
    logic hit;
  } segint_flag_t;

endpackage
`default_nettype wire

>>> hdl/segint_cross.sv
// Front of the pipeline: direction vectors, cross products, sign fix and hit test.
// Depends on segint_pkg.
`default_nettype none
module segint_cross import segint_pkg::*; #(
  parameter int C = 16
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     en,
  input  wire                     in_vld,
  input  wire logic signed [C-1:0] ax,
  input  wire logic signed [C-1:0] ay,
  input  wire logic signed [C-1:0] bx,
  input  wire logic signed [C-1:0] by,
  input  wire logic signed [C-1:0] cx,
  input  wire logic signed [C-1:0] cy,
  input  wire logic signed [C-1:0] dx,
  input  wire logic signed [C-1:0] dy,
  output segint_flag_t            flag,
  output logic [2*C+1:0]          den,
  output logic [2*C+1:0]          tn,
  output logic signed [C:0]       rx,
  output logic signed [C:0]       ry,
  output logic signed [C-1:0]     bax,
  output logic signed [C-1:0]     bay
);

  localparam int DW   = C + 1;
  localparam int PW   = 2 * C + 2;
  localparam int XW   = 2 * C + 3;
  localparam int DENW = 2 * C + 2;

  logic v1, v2, v3, v4, v5;
  logic signed [DW-1:0] rx1, ry1, sx1, sy1, qx1, qy1;
  logic signed [C-1:0]  ax1, ay1, ax2, ay2, ax3, ay3, ax4, ay4, ax5, ay5;
  logic signed [DW-1:0] rx2, ry2, rx3, ry3, rx4, ry4, rx5, ry5;
  logic signed [PW-1:0] m_rs, m_rysx, m_qs, m_qysx, m_qr, m_qyrx;
  logic signed [XW-1:0] den3, tn3, un3, den4, tn4, un4;
  logic                 nz4, hit5;
  logic [DENW-1:0]      den5, tn5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx1 <= DW'(bx) - DW'(ax);
      ry1 <= DW'(by) - DW'(ay);
      sx1 <= DW'(dx) - DW'(cx);
      sy1 <= DW'(dy) - DW'(cy);
      qx1 <= DW'(cx) - DW'(ax);
      qy1 <= DW'(cy) - DW'(ay);
      ax1 <= ax;
      ay1 <= ay;

      m_rs   <= PW'(rx1) * PW'(sy1);
      m_rysx <= PW'(ry1) * PW'(sx1);
      m_qs   <= PW'(qx1) * PW'(sy1);
      m_qysx <= PW'(qy1) * PW'(sx1);
      m_qr   <= PW'(qx1) * PW'(ry1);
      m_qyrx <= PW'(qy1) * PW'(rx1);
      rx2 <= rx1;
      ry2 <= ry1;
      ax2 <= ax1;
      ay2 <= ay1;

      den3 <= XW'(m_rs) - XW'(m_rysx);
      tn3  <= XW'(m_qs) - XW'(m_qysx);
      un3  <= XW'(m_qr) - XW'(m_qyrx);
      rx3 <= rx2;
      ry3 <= ry2;
      ax3 <= ax2;
      ay3 <= ay2;

      // Make the determinant positive so that both parameter tests are plain compares.
      nz4  <= (den3 != '0);
      den4 <= den3[XW-1] ? -den3 : den3;
      tn4  <= den3[XW-1] ? -tn3 : tn3;
      un4  <= den3[XW-1] ? -un3 : un3;
      rx4 <= rx3;
      ry4 <= ry3;
      ax4 <= ax3;
      ay4 <= ay3;

      hit5 <= nz4 && !tn4[XW-1] && (tn4 <= den4) && !un4[XW-1] && (un4 <= den4);
      den5 <= den4[DENW-1:0];
      tn5  <= tn4[DENW-1:0];
      rx5 <= rx4;
      ry5 <= ry4;
      ax5 <= ax4;
      ay5 <= ay4;
    end
  end

  assign flag.vld = v5;
  assign flag.hit = hit5;
  assign den = den5;
  assign tn  = tn5;
  assign rx  = rx5;
  assign ry  = ry5;
  assign bax = ax5;
  assign bay = ay5;

endmodule
`default_nettype wire

>>> hdl/segint_numer.sv
// Forms the scaled numerator magnitude and its sign for one coordinate.
// Depends on segint_pkg.
`default_nettype none
module segint_numer import segint_pkg::*; #(
  parameter int C = 16,
  parameter int F = 16
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      en,
  input  segint_flag_t             in_flag,
  input  wire logic [2*C+1:0]      den,
  input  wire logic [2*C+1:0]      tn,
  input  wire logic signed [C:0]   r,
  input  wire logic signed [C-1:0] base,
  output segint_flag_t             out_flag,
  output logic [2*C+1:0]           out_den,
  output logic [3*C+4+F:0]         mag,
  output logic                     neg
);

  localparam int DENW = 2 * C + 2;
  localparam int NW   = 3 * C + 5;
  localparam int MW   = NW + F;

  segint_flag_t f6, f7, f8;
  logic [DENW-1:0]      d6, d7, d8;
  logic signed [NW-1:0] p6, b6, n7;
  logic [MW-1:0]        m8;
  logic                 neg8;

  always_ff @(posedge clk) begin
    if (rst) begin
      f6.vld <= 1'b0;
      f7.vld <= 1'b0;
      f8.vld <= 1'b0;
    end else if (en) begin
      f6.vld <= in_flag.vld;
      f7.vld <= f6.vld;
      f8.vld <= f7.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // The crossing coordinate is (base*den + tn*r) / den.
      p6 <= NW'($signed({1'b0, tn})) * NW'(r);
      b6 <= NW'($signed({1'b0, den})) * NW'(base);
      d6 <= den;
      f6.hit <= in_flag.hit;

      n7 <= p6 + b6;
      d7 <= d6;
      f7.hit <= f6.hit;

      neg8 <= n7[NW-1];
      m8   <= MW'(n7[NW-1] ? -n7 : n7) << F;
      d8   <= d7;
      f8.hit <= f7.hit;
    end
  end

  assign out_flag = f8;
  assign out_den  = d8;
  assign mag      = m8;
  assign neg      = neg8;

endmodule
`default_nettype wire

>>> hdl/segint_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on segint_pkg.
`default_nettype none
module segint_div import segint_pkg::*; #(
  parameter int DENW = 34,
  parameter int QB   = 32,
  parameter int MW   = 69
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               en,
  input  segint_flag_t      in_flag,
  input  wire logic [MW-1:0]   num,
  input  wire logic [DENW-1:0] den,
  input  wire logic         in_neg,
  output segint_flag_t      out_flag,
  output logic [QB-1:0]     quo,
  output logic              out_neg
);

  logic [DENW-1:0] rem_q [QB];
  logic [QB-1:0]   rq_q  [QB];
  logic [DENW-1:0] dd_q  [QB];
  logic            ng_q  [QB];
  segint_flag_t    fl_q  [QB];

  logic [DENW-1:0] rem_s [QB];
  logic [QB-1:0]   rq_s  [QB];
  logic [DENW-1:0] dd_s  [QB];
  logic            ng_s  [QB];
  segint_flag_t    fl_s  [QB];

  // The quotient is known to fit in QB bits, so the partial remainder starts
  // from the bits above them and stays below the divisor.
  always_comb begin
    rem_s[0] = num[QB+DENW-1:QB];
    rq_s[0]  = num[QB-1:0];
    dd_s[0]  = den;
    ng_s[0]  = in_neg;
    fl_s[0]  = in_flag;
    for (int k = 1; k < QB; k++) begin
      rem_s[k] = rem_q[k-1];
      rq_s[k]  = rq_q[k-1];
      dd_s[k]  = dd_q[k-1];
      ng_s[k]  = ng_q[k-1];
      fl_s[k]  = fl_q[k-1];
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [DENW:0] trial;
    logic [DENW:0] diff;
    logic          ge;

    assign trial = {rem_s[i], rq_s[i][QB-1]};
    assign diff  = trial - {1'b0, dd_s[i]};
    assign ge    = (trial >= {1'b0, dd_s[i]});

    always_ff @(posedge clk) begin
      if (rst) begin
        fl_q[i].vld <= 1'b0;
      end else if (en) begin
        fl_q[i].vld <= fl_s[i].vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]    <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
        rq_q[i]     <= {rq_s[i][QB-2:0], ge};
        dd_q[i]     <= dd_s[i];
        ng_q[i]     <= ng_s[i];
        fl_q[i].hit <= fl_s[i].hit;
      end
    end
  end

  assign out_flag = fl_q[QB-1];
  assign quo      = rq_q[QB-1];
  assign out_neg  = ng_q[QB-1];

endmodule
`default_nettype wire

>>> hdl/segment_intersection_top.sv
// Path: segint_cross, segint_numer and segint_div stages, then the output register.
// Throughput: one item per cycle while no result waits unclaimed; every stage
// is a register and the divider retires one quotient bit per stage.
// Reset: synchronous active-high rst clears all valid bits; no other state.
// Depends on segint_pkg, segint_cross, segint_numer and segint_div.
`default_nettype none
module segment_intersection_top import segint_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       s_tvalid,
  output logic                      s_tready,
  // Fields from the lowest bit up: a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y.
  input  wire logic [8*COORD_BITS-1:0] s_tdata,
  output logic                      m_tvalid,
  input  wire                       m_tready,
  // Fields from the lowest bit up: cross_x, cross_y.
  output logic [2*OUT_W-1:0]        m_tdata,
  // Fields from the lowest bit up: hit.
  output logic                      m_tuser
);

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int DENW = 2 * C + 2;
  localparam int NW   = 3 * C + 5;
  localparam int MW   = NW + F;
  localparam int QB   = C + F;
  localparam int VW   = (QB + 1 > OUT_W + 1) ? QB + 1 : OUT_W + 1;
  localparam logic signed [VW-1:0] SMAX = VW'({1'b0, {(OUT_W-1){1'b1}}});
  localparam logic signed [VW-1:0] SMIN = -SMAX - VW'(1);

  // The whole pipeline moves together; it holds when a result waits unclaimed.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  segint_flag_t        fc, fnx, fny, fdx, fdy;
  logic [DENW-1:0]     den, tn, dnx, dny;
  logic signed [C:0]   rx, ry;
  logic signed [C-1:0] ax, ay;
  logic [MW-1:0]       mx, my;
  logic                ngx, ngy, qngx, qngy;
  logic [QB-1:0]       qx, qy;

  segint_cross #(.C(C)) u_cross (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (s_tvalid && s_tready),
    .ax     (s_tdata[0*C +: C]),
    .ay     (s_tdata[1*C +: C]),
    .bx     (s_tdata[2*C +: C]),
    .by     (s_tdata[3*C +: C]),
    .cx     (s_tdata[4*C +: C]),
    .cy     (s_tdata[5*C +: C]),
    .dx     (s_tdata[6*C +: C]),
    .dy     (s_tdata[7*C +: C]),
    .flag   (fc),
    .den    (den),
    .tn     (tn),
    .rx     (rx),
    .ry     (ry),
    .bax    (ax),
    .bay    (ay)
  );

  segint_numer #(.C(C), .F(F)) u_numer_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_flag  (fc),
    .den      (den),
    .tn       (tn),
    .r        (rx),
    .base     (ax),
    .out_flag (fnx),
    .out_den  (dnx),
    .mag      (mx),
    .neg      (ngx)
  );

  segint_numer #(.C(C), .F(F)) u_numer_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_flag  (fc),
    .den      (den),
    .tn       (tn),
    .r        (ry),
    .base     (ay),
    .out_flag (fny),
    .out_den  (dny),
    .mag      (my),
    .neg      (ngy)
  );

  segint_div #(.DENW(DENW), .QB(QB), .MW(MW)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_flag  (fnx),
    .num      (mx),
    .den      (dnx),
    .in_neg   (ngx),
    .out_flag (fdx),
    .quo      (qx),
    .out_neg  (qngx)
  );

  segint_div #(.DENW(DENW), .QB(QB), .MW(MW)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_flag  (fny),
    .num      (my),
    .den      (dny),
    .in_neg   (ngy),
    .out_flag (fdy),
    .quo      (qy),
    .out_neg  (qngy)
  );

  // Apply the sign (truncation toward zero falls out of dividing magnitudes),
  // then clamp to the signed 32-bit range. A miss forces both coordinates to 0.
  logic signed [VW-1:0] vx, vy;
  logic signed [VW-1:0] sx, sy;

  always_comb begin
    vx = qngx ? -VW'(qx) : VW'(qx);
    vy = qngy ? -VW'(qy) : VW'(qy);
    sx = (vx > SMAX) ? SMAX : ((vx < SMIN) ? SMIN : vx);
    sy = (vy > SMAX) ? SMAX : ((vy < SMIN) ? SMIN : vy);
  end

  // Both coordinate lanes carry the same flags in lockstep.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= fdx.vld & fdy.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= fdx.hit & fdy.hit;
      m_tdata <= fdx.hit ? {sy[OUT_W-1:0], sx[OUT_W-1:0]} : '0;
    end
  end

endmodule
`default_nettype wire
